FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssw checker: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssw checker: next-cycle property violated");

`endif

FILE: src/ssw_pkg.sv
// ---------------------------------------------------------------------------
// ssw_pkg
// Types and constants of the structure table walker.
// ---------------------------------------------------------------------------
package ssw_pkg;

	localparam int OffsetBits = 16;
	localparam int MaxStrings = 256;
	localparam int MaxRes     = 3;
	localparam int StrNumW    = $clog2(MaxStrings + 1);
	localparam int PosW       = OffsetBits + 1;
	localparam int TotW       = PosW + 1;
	localparam int ResCntW    = $clog2(MaxRes + 1);

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_FORMAT = 3'd1,
		PH_FIRST  = 3'd2,
		PH_INSTR  = 3'd3,
		PH_ZERO   = 3'd4
	} walk_phase_t;

	typedef enum logic [2:0] {
		REC_STRING  = 3'd0,
		REC_DONE    = 3'd1,
		REC_END     = 3'd2,
		REC_OVERRUN = 3'd3,
		REC_SHORT   = 3'd4
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t             rec_kind;
		logic [OffsetBits-1:0] struct_offset;
		logic [7:0]            struct_type;
		logic [7:0]            formatted_length;
		logic [15:0]           struct_handle;
		logic [StrNumW-1:0]    string_number;
		logic [OffsetBits-1:0] string_offset;
		logic [PosW-1:0]       struct_size;
		logic                  last;
	} rec_t;

	typedef rec_t [MaxRes-1:0] rec_arr_t;

	typedef struct packed {
		logic [OffsetBits-1:0] table_pos;
		logic [OffsetBits-1:0] start;
		logic [PosW-1:0]       pos;
		walk_phase_t           phase;
		logic [7:0]            stype;
		logic [7:0]            slen;
		logic [15:0]           handle;
		logic [StrNumW-1:0]    nstr;
		logic                  stopped;
	} walk_state_t;

	localparam walk_state_t WalkReset = '{
		table_pos: '0,
		start:     '0,
		pos:       '0,
		phase:     PH_HEADER,
		stype:     '0,
		slen:      '0,
		handle:    '0,
		nstr:      '0,
		stopped:   1'b0
	};

endpackage

FILE: src/ssw_if.sv
// ---------------------------------------------------------------------------
// ssw_if
// Valid/ready channels of the walker: table bytes in, records out.
// ---------------------------------------------------------------------------
interface ssw_in_if import ssw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] table_byte;
	logic       restart;

	modport source (output valid, table_byte, restart, input ready);
	modport sink   (input valid, table_byte, restart, output ready);
endinterface

interface ssw_out_if import ssw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [2:0]            rec_kind;
	logic [OffsetBits-1:0] struct_offset;
	logic [7:0]            struct_type;
	logic [7:0]            formatted_length;
	logic [15:0]           struct_handle;
	logic [StrNumW-1:0]    string_number;
	logic [OffsetBits-1:0] string_offset;
	logic [PosW-1:0]       struct_size;
	logic                  last;

	modport source (output valid, rec_kind, struct_offset, struct_type, formatted_length,
		struct_handle, string_number, string_offset, struct_size, last, input ready);
	modport sink   (input valid, rec_kind, struct_offset, struct_type, formatted_length,
		struct_handle, string_number, string_offset, struct_size, last, output ready);
endinterface

FILE: src/ssw_step.sv
// ---------------------------------------------------------------------------
// ssw_step
// Next walk state and up to three records for one table byte.
// ---------------------------------------------------------------------------
module ssw_step import ssw_pkg::*; (
	input  walk_state_t            state,
	input  logic [7:0]             table_byte,
	input  logic                   restart,
	input  logic [OffsetBits-1:0]  table_length,
	output walk_state_t            next_state,
	output rec_arr_t               recs,
	output logic [ResCntW-1:0]     rec_count
);

	function automatic rec_t make_rec(input rec_kind_t kind, input logic hdr,
			input walk_state_t s, input logic [OffsetBits-1:0] offset,
			input logic [StrNumW-1:0] num, input logic [OffsetBits-1:0] soff,
			input logic [PosW-1:0] total);
		rec_t r;
		r.rec_kind         = kind;
		r.struct_offset    = offset;
		r.struct_type      = hdr ? s.stype  : '0;
		r.formatted_length = hdr ? s.slen   : '0;
		r.struct_handle    = hdr ? s.handle : '0;
		r.string_number    = num;
		r.string_offset    = soff;
		r.struct_size      = total;
		r.last             = 1'b0;
		return r;
	endfunction

	// Append a record; anything past the third is dropped.
	function automatic void push(inout rec_arr_t rs, inout logic [ResCntW-1:0] n,
			input rec_t r);
		if (n < ResCntW'(MaxRes)) begin
			rs[n] = r;
			n     = n + ResCntW'(1);
		end
	endfunction

	function automatic void close_struct(inout walk_state_t s, inout rec_arr_t rs,
			inout logic [ResCntW-1:0] n, input logic [TotW-1:0] total,
			input logic [OffsetBits-1:0] tlen);
		logic [TotW-1:0] nxt;
		push(rs, n, make_rec(REC_DONE, 1'b1, s, s.start, s.nstr, '0, total[PosW-1:0]));
		nxt = TotW'(s.start) + total;
		if (nxt + TotW'(4) > TotW'(tlen)) begin
			push(rs, n, make_rec(REC_END, 1'b0, s, nxt[OffsetBits-1:0], '0, '0, '0));
			s.stopped = 1'b1;
		end else begin
			s.start = nxt[OffsetBits-1:0];
			s.pos   = '0;
			s.phase = PH_HEADER;
		end
	endfunction

	function automatic void start_string(inout walk_state_t s, inout rec_arr_t rs,
			inout logic [ResCntW-1:0] n, input logic [PosW-1:0] rel);
		if (s.nstr < StrNumW'(MaxStrings)) begin
			push(rs, n, make_rec(REC_STRING, 1'b1, s, s.start, s.nstr,
				rel[OffsetBits-1:0], '0));
			s.nstr = s.nstr + StrNumW'(1);
		end
		s.phase = PH_INSTR;
	endfunction

	function automatic void string_byte(inout walk_state_t s, inout rec_arr_t rs,
			inout logic [ResCntW-1:0] n, input logic [7:0] b,
			input logic [OffsetBits-1:0] tlen);
		logic [PosW-1:0] rel;
		logic            closed;
		rel    = s.pos;
		closed = 1'b0;
		case (s.phase)
			PH_FIRST: begin
				if (b != 8'h00) start_string(s, rs, n, rel);
				else s.phase = PH_ZERO;
			end
			PH_INSTR: begin
				if (b == 8'h00) s.phase = PH_ZERO;
			end
			default: begin
				if (b == 8'h00) begin
					close_struct(s, rs, n, TotW'(rel) + TotW'(1), tlen);
					closed = 1'b1;
				end else begin
					start_string(s, rs, n, rel);
				end
			end
		endcase
		if (!closed) s.pos = s.pos + PosW'(1);
	endfunction

	always_comb begin : step_logic
		walk_state_t         s;
		rec_arr_t            rs;
		logic [ResCntW-1:0]  n;
		logic [7:0]          b;
		s  = state;
		rs = '0;
		n  = '0;
		if (restart) s = WalkReset;
		// bytes past the end of the table read as zero
		b = (s.table_pos < table_length) ? table_byte : 8'h00;

		if (!s.stopped) begin
			case (s.phase)
				PH_HEADER: begin
					if (s.pos == '0) begin
						s.nstr = '0;
						if (TotW'(s.start) + TotW'(4) > TotW'(table_length)) begin
							push(rs, n, make_rec(REC_END, 1'b0, s, s.start, '0, '0, '0));
							s.stopped = 1'b1;
						end
					end
					if (!s.stopped) begin
						case (s.pos)
							PosW'(0): s.stype  = b;
							PosW'(1): s.slen   = b;
							PosW'(2): s.handle = {8'h00, b};
							default:  s.handle = {b, s.handle[7:0]};
						endcase
						s.pos = s.pos + PosW'(1);
						if (s.pos >= PosW'(4)) begin
							if (TotW'(s.start) + TotW'(s.slen) > TotW'(table_length)) begin
								push(rs, n, make_rec(REC_OVERRUN, 1'b1, s, s.start,
									'0, '0, '0));
								s.stopped = 1'b1;
							end else if (s.slen < 8'd4) begin
								push(rs, n, make_rec(REC_SHORT, 1'b1, s, s.start,
									'0, '0, '0));
								s.stopped = 1'b1;
							end else begin
								s.phase = (s.slen == 8'd4) ? PH_FIRST : PH_FORMAT;
							end
						end
					end
				end
				PH_FORMAT: begin
					s.pos = s.pos + PosW'(1);
					if (s.pos >= PosW'(s.slen)) s.phase = PH_FIRST;
				end
				default: begin
					string_byte(s, rs, n, b, table_length);
				end
			endcase

			// last table byte: feed the trailing zeros to close a cut-short string set
			if (TotW'(s.table_pos) + TotW'(1) >= TotW'(table_length)) begin
				for (int k = 0; k < 3; k++) begin
					if (!s.stopped && s.phase >= PH_FIRST)
						string_byte(s, rs, n, 8'h00, table_length);
				end
			end
		end

		s.table_pos = s.table_pos + OffsetBits'(1);
		if (n != '0) rs[n - ResCntW'(1)].last = 1'b1;

		next_state = s;
		recs       = rs;
		rec_count  = n;
	end

endmodule

FILE: src/smbios_structure_walker.sv
// ---------------------------------------------------------------------------
// smbios_structure_walker
// Byte-serial walker over an SMBIOS structure table.
// ---------------------------------------------------------------------------
// Feed the structure table one byte per transfer on items, in table order,
// with restart set on the byte at offset zero. cfg_wdata written with cfg_we
// sets the table length in bytes; write it while the walker is idle. Each
// byte yields zero to three records on results: a string start, a structure
// done (with string count and total structure size), the table end, or a stop
// for a structure that overruns the table or has a length under 4. The last
// record caused by a byte carries last. The walker takes one byte per clock
// as long as each byte produces at most one record and results is not
// stalled; a byte producing more than one record holds the three-entry record
// buffer until its last record transfers. A byte waits in the input register
// until the record buffer has room, then its records load into the record
// buffer, from which the first record is offered on results.
// Bytes past the table length read as zero, so a structure cut short is
// closed on the last table byte.
module smbios_structure_walker import ssw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	ssw_in_if.sink                 items,
	ssw_out_if.source              results,
	input  logic                   cfg_we,
	input  logic [OffsetBits-1:0]  cfg_wdata
);

	logic [OffsetBits-1:0] table_length_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	// walk state and record buffer
	walk_state_t          state_q;
	walk_state_t          next_state;
	rec_arr_t             recs;
	logic [ResCntW-1:0]   rec_count;
	rec_arr_t             res_q;
	logic [ResCntW-1:0]   res_cnt_q;
	logic [ResCntW-1:0]   res_idx_q;
	rec_t                 cur_rec;

	logic out_valid;
	logic room;
	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (cfg_we) begin
			table_length_q <= cfg_wdata;
		end
	end

	// The record buffer frees up when it is empty or its final record
	// transfers this cycle; only then may the byte in s1 move on.
	assign out_valid   = res_idx_q < res_cnt_q;
	assign room        = !out_valid || (results.ready && (res_idx_q + ResCntW'(1) == res_cnt_q));
	assign advance     = valid_s1 && room;
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			byte_s1    <= items.table_byte;
			restart_s1 <= items.restart;
		end
	end

	ssw_step u_step (
		.state        (state_q),
		.table_byte   (byte_s1),
		.restart      (restart_s1),
		.table_length (table_length_q),
		.next_state   (next_state),
		.recs         (recs),
		.rec_count    (rec_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WalkReset;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
			res_idx_q <= '0;
		end else if (advance) begin
			res_cnt_q <= rec_count;
			res_idx_q <= '0;
		end else if (out_valid && results.ready) begin
			res_idx_q <= res_idx_q + ResCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= recs;
	end

	always_comb begin
		case (res_idx_q)
			ResCntW'(1): cur_rec = res_q[1];
			ResCntW'(2): cur_rec = res_q[2];
			default:     cur_rec = res_q[0];
		endcase
	end

	assign results.valid            = out_valid;
	assign results.rec_kind         = cur_rec.rec_kind;
	assign results.struct_offset    = cur_rec.struct_offset;
	assign results.struct_type      = cur_rec.struct_type;
	assign results.formatted_length = cur_rec.formatted_length;
	assign results.struct_handle    = cur_rec.struct_handle;
	assign results.string_number    = cur_rec.string_number;
	assign results.string_offset    = cur_rec.string_offset;
	assign results.struct_size      = cur_rec.struct_size;
	assign results.last             = cur_rec.last;

endmodule

FILE: src/ssw_checker.sv
// ---------------------------------------------------------------------------
// ssw_checker
// Port-level properties of the walker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssw_checker import ssw_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic [2:0]          rec_kind,
	input logic [StrNumW-1:0]  string_number,
	input logic [PosW-1:0]     struct_size,
	input logic                last
);

	// a stalled record holds
	`ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(rec_kind) && $stable(last))

	// records of one byte leave back to back
	`ASSERT_NEXT(a_burst, clk, arst_n, res_valid && res_ready && !last, res_valid)

	// a record that stops the walk is the final one for its byte
	`ASSERT_SAME(a_stop_last, clk, arst_n, res_valid && (rec_kind == REC_END || rec_kind == REC_OVERRUN || rec_kind == REC_SHORT), last)

	// string starts stay under the string limit and carry no length
	`ASSERT_SAME(a_string, clk, arst_n, res_valid && rec_kind == REC_STRING, string_number < StrNumW'(MaxStrings) && struct_size == '0)

endmodule

bind smbios_structure_walker ssw_checker u_ssw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.rec_kind      (results.rec_kind),
	.string_number (results.string_number),
	.struct_size   (results.struct_size),
	.last          (results.last)
);

FILE: dv/smbios_walk_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smbios_walk_checker
// Watches the byte and record channels of the structure table walker,
// predicts the records of every accepted table byte and compares them in
// order. Hands the error count and the number of outstanding records to the
// testbench top.
// ---------------------------------------------------------------------------
module smbios_walk_checker import ssw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ssw_in_if                     items,
	ssw_out_if                    results,
	input  logic                  cfg_we,
	input  logic [OffsetBits-1:0] cfg_wdata,
	output int                    n_errors,
	output int                    n_pending
);

	rec_t                  expected_recs[$];

	// Walk state as seen by the predictor
	logic [OffsetBits-1:0] tbl_len;
	logic [OffsetBits-1:0] w_tpos;
	logic [OffsetBits-1:0] w_start;
	logic [PosW-1:0]       w_pos;
	walk_phase_t           w_phase;
	logic [7:0]            w_type;
	logic [7:0]            w_flen;
	logic [15:0]           w_handle;
	logic [StrNumW-1:0]    w_nstr;
	logic                  w_stopped;
	int                    n_made;	// records caused by the current byte

	task automatic clear_walk();
		w_tpos    = '0;
		w_start   = '0;
		w_pos     = '0;
		w_phase   = PH_HEADER;
		w_type    = '0;
		w_flen    = '0;
		w_handle  = '0;
		w_nstr    = '0;
		w_stopped = 1'b0;
	endtask

	// Records past MaxRes for one byte are dropped, state still moves on.
	task automatic push_rec(input rec_kind_t kind, input bit with_hdr,
		input longint unsigned offs, input longint unsigned num,
		input longint unsigned soff, input longint unsigned total);
		rec_t r;
		if (n_made < MaxRes) begin
			r.rec_kind         = kind;
			r.struct_offset    = OffsetBits'(offs);
			r.struct_type      = with_hdr ? w_type : 8'd0;
			r.formatted_length = with_hdr ? w_flen : 8'd0;
			r.struct_handle    = with_hdr ? w_handle : 16'd0;
			r.string_number    = StrNumW'(num);
			r.string_offset    = OffsetBits'(soff);
			r.struct_size      = PosW'(total);
			r.last             = 1'b0;
			expected_recs.push_back(r);
			n_made++;
		end
	endtask

	task automatic close_struct(input longint unsigned total);
		longint unsigned nxt;
		push_rec(REC_DONE, 1'b1, w_start, w_nstr, 0, total);
		nxt = longint'(w_start) + total;
		if (nxt + 4 > longint'(tbl_len)) begin
			push_rec(REC_END, 1'b0, nxt, 0, 0, 0);
			w_stopped = 1'b1;
		end else begin
			w_start = OffsetBits'(nxt);
			w_pos   = '0;
			w_phase = PH_HEADER;
		end
	endtask

	task automatic start_string(input longint unsigned rel);
		if (w_nstr < MaxStrings) begin
			push_rec(REC_STRING, 1'b1, w_start, w_nstr, rel, 0);
			w_nstr = w_nstr + 1'b1;
		end
		w_phase = PH_INSTR;
	endtask

	task automatic string_byte(input logic [7:0] b);
		longint unsigned rel;
		bit              closed;
		rel    = w_pos;
		closed = 1'b0;
		case (w_phase)
			PH_FIRST: begin
				if (b != 8'd0)
					start_string(rel);
				else
					w_phase = PH_ZERO;
			end
			PH_INSTR: begin
				if (b == 8'd0)
					w_phase = PH_ZERO;
			end
			default: begin
				if (b == 8'd0) begin
					close_struct(rel + 1);
					closed = 1'b1;
				end else begin
					start_string(rel);
				end
			end
		endcase
		if (!closed)
			w_pos = w_pos + 1'b1;
	endtask

	task automatic walk_byte(input logic [7:0] din, input logic rst_walk);
		logic [7:0] b;
		int         k;
		n_made = 0;
		if (rst_walk)
			clear_walk();
		b = (w_tpos < tbl_len) ? din : 8'd0;
		if (!w_stopped) begin
			if (w_phase == PH_HEADER) begin
				if (w_pos == '0) begin
					w_nstr = '0;
					if (32'(w_start) + 32'd4 > 32'(tbl_len)) begin
						push_rec(REC_END, 1'b0, w_start, 0, 0, 0);
						w_stopped = 1'b1;
					end
				end
				if (!w_stopped) begin
					case (w_pos)
						0:       w_type = b;
						1:       w_flen = b;
						2:       w_handle = {8'd0, b};
						default: w_handle[15:8] = b;
					endcase
					w_pos = w_pos + 1'b1;
					if (w_pos >= 4) begin
						if (32'(w_start) + 32'(w_flen) > 32'(tbl_len)) begin
							push_rec(REC_OVERRUN, 1'b1, w_start, 0, 0, 0);
							w_stopped = 1'b1;
						end else if (w_flen < 8'd4) begin
							push_rec(REC_SHORT, 1'b1, w_start, 0, 0, 0);
							w_stopped = 1'b1;
						end else if (w_flen == 8'd4) begin
							w_phase = PH_FIRST;
						end else begin
							w_phase = PH_FORMAT;
						end
					end
				end
			end else if (w_phase == PH_FORMAT) begin
				w_pos = w_pos + 1'b1;
				if (w_pos >= w_flen)
					w_phase = PH_FIRST;
			end else begin
				string_byte(b);
			end
			// last table byte inside the string set: the zeros after it close it now
			if (32'(w_tpos) + 32'd1 >= 32'(tbl_len)) begin
				for (k = 0; k < 3; k++) begin
					if (w_stopped || w_phase < PH_FIRST)
						break;
					string_byte(8'd0);
				end
			end
		end
		w_tpos = w_tpos + 1'b1;
		if (n_made > 0)
			expected_recs[expected_recs.size() - 1].last = 1'b1;
	endtask

	task automatic cmp_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			n_errors++;
		end
	endtask

	task automatic check_record();
		rec_t want;
		if (expected_recs.size() == 0) begin
			$error("unexpected record: rec_kind %0d struct_offset 0x%0h",
				results.rec_kind, results.struct_offset);
			n_errors++;
		end else begin
			want = expected_recs.pop_front();
			cmp_field("rec_kind", want.rec_kind, results.rec_kind);
			cmp_field("struct_offset", want.struct_offset, results.struct_offset);
			cmp_field("struct_type", want.struct_type, results.struct_type);
			cmp_field("formatted_length", want.formatted_length, results.formatted_length);
			cmp_field("struct_handle", want.struct_handle, results.struct_handle);
			cmp_field("string_number", want.string_number, results.string_number);
			cmp_field("string_offset", want.string_offset, results.string_offset);
			cmp_field("struct_size", want.struct_size, results.struct_size);
			cmp_field("last", want.last, results.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_len = '0;
			clear_walk();
			expected_recs.delete();
			n_errors  = 0;
			n_pending = 0;
		end else begin
			if (cfg_we)
				tbl_len = cfg_wdata;
			if (items.valid && items.ready)
				walk_byte(items.table_byte, items.restart);
			if (results.valid && results.ready)
				check_record();
			n_pending = expected_recs.size();
		end
	end

endmodule

FILE: dv/smbios_structure_walker_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smbios_structure_walker_tb
// Streams structure tables into the walker: a few hand-built tables for the
// corner cases, then random tables with random gaps on both channels and a
// long record stall while bytes keep coming. The checker beside the walker
// predicts and compares every record.
// ---------------------------------------------------------------------------
module smbios_structure_walker_tb;
	import ssw_pkg::*;

	localparam int IdleLimit   = 1000;	// cycles without any transfer
	localparam int HoldCycles  = 80;	// long stall of the record sink
	localparam int DrainCycles = 10;	// walker latency plus margin
	localparam int RandItems   = 75;
	localparam int HoldTable   = 0;	// index of the table sent under a long stall

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [OffsetBits-1:0] cfg_wdata;

	ssw_in_if  items_if ();
	ssw_out_if results_if ();

	int         n_errors;
	int         n_pending;
	bit         burst = 1'b0;	// both sides run without gaps
	bit         hold_req = 1'b0;	// asks the record sink for a long stall
	int         idle_cycles = 0;
	logic [7:0] tbl_q[$];	// table image being built

	smbios_structure_walker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	smbios_walk_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.n_errors  (n_errors),
		.n_pending (n_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (items_if.valid && items_if.ready)
			|| (results_if.valid && results_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$error("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("smbios_structure_walker_tb NOT OK");
				$finish;
			end
		end
	end

	// Record sink: random ready gaps per record, and one long stall on request
	// so the walker's record buffer fills and it stops taking bytes.
	initial begin : record_sink
		int gap;
		results_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				results_if.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = burst ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				results_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do @(posedge clk); while (!results_if.valid);
		end
	end

	// One byte transfer, after a random gap. Valid stays high between
	// back-to-back bytes.
	task automatic send_byte(input logic [7:0] b, input logic rs);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid      <= 1'b1;
		items_if.table_byte <= b;
		items_if.restart    <= rs;
		do @(posedge clk); while (!items_if.ready);
	endtask

	// Stop sending and wait until every predicted record has come out, then
	// give bytes that make no record time to leave the pipeline.
	task automatic settle();
		items_if.valid <= 1'b0;
		@(posedge clk);
		wait (n_pending == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Appends one structure. A formatted length under 4 or far past the table
	// gives a bare header, since the walk stops right after it.
	task automatic put_struct(input int flen, input int n_strings, input int str_max,
		input bit odd_zero);
		int i;
		int j;
		int n_chars;
		tbl_q.push_back(8'($urandom_range(0, 255)));
		tbl_q.push_back(8'(flen));
		tbl_q.push_back(8'($urandom_range(0, 255)));
		tbl_q.push_back(8'($urandom_range(0, 255)));
		if (flen >= 4 && flen < 64) begin
			for (i = 4; i < flen; i++)
				tbl_q.push_back(8'($urandom_range(0, 255)));
			if (n_strings == 0) begin
				tbl_q.push_back(8'd0);
				tbl_q.push_back(8'd0);
			end else begin
				// lone zero right after the formatted area, strings follow
				if (odd_zero)
					tbl_q.push_back(8'd0);
				for (i = 0; i < n_strings; i++) begin
					n_chars = $urandom_range(1, str_max);
					for (j = 0; j < n_chars; j++)
						tbl_q.push_back(8'($urandom_range(1, 255)));
					tbl_q.push_back(8'd0);
				end
				tbl_q.push_back(8'd0);
			end
		end
	endtask

	// Writes the table length while idle, then streams n_send bytes; bytes past
	// the built image are random. A rare restart mid-stream adds noise.
	task automatic run_table(input logic [OffsetBits-1:0] tlen, input int n_send,
		input bit rs_first, input bit hold);
		int         i;
		logic [7:0] b;
		logic       rs;
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= tlen;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (hold)
			hold_req = 1'b1;
		for (i = 0; i < n_send; i++) begin
			b  = (i < tbl_q.size()) ? tbl_q[i] : 8'($urandom_range(0, 255));
			rs = (i == 0) ? rs_first : ($urandom_range(0, 63) == 0);
			send_byte(b, rs);
		end
		tbl_q.delete();
	endtask

	initial begin : stimulus
		int n_rand;
		int t;
		int s;
		int mode;
		int size;
		int tlen;
		int n_send;
		arst_n              = 1'b0;
		items_if.valid      = 1'b0;
		items_if.table_byte = 8'd0;
		items_if.restart    = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Table length still at its reset value of zero: no header fits.
		send_byte(8'hFF, 1'b1);
		run_table(16'd0, 1, 1'b1, 1'b0);

		// All-ones header, lone zero before its one string, then a second
		// header with a formatted length under 4.
		tbl_q = '{8'hFF, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00,
			8'h00, 8'h03, 8'h00, 8'h00};
		run_table(16'd12, 12, 1'b1, 1'b0);

		// Formatted area runs past the table; the trailing byte hits a stopped walk.
		tbl_q = '{8'h01, 8'hFF, 8'h12, 8'h34};
		run_table(16'd8, 5, 1'b1, 1'b0);

		// Table ends inside a string: closed on the last byte, then table end.
		tbl_q = '{8'h02, 8'h04, 8'h00, 8'h00, 8'h41, 8'h42};
		run_table(16'd6, 6, 1'b1, 1'b0);

		// Random tables
		n_rand = 0;
		t      = 0;
		while (n_rand < RandItems) begin
			burst = ($urandom_range(0, 3) == 0);
			if (t == HoldTable) begin
				// the record sink stalls while bytes keep coming
				burst = 1'b1;
				put_struct(4, 8, 1, 1'b0);
				n_send = tbl_q.size();
				run_table(16'(n_send), n_send, 1'b1, 1'b1);
				n_rand += n_send;
			end else begin
				mode = $urandom_range(0, 9);
				for (s = $urandom_range(1, 3); s > 0; s--)
					put_struct($urandom_range(4, 10), $urandom_range(0, 3), 4,
						($urandom_range(0, 7) == 0));
				if ($urandom_range(0, 3) == 0)
					put_struct(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
						: $urandom_range(200, 255), 0, 1, 1'b0);
				size = tbl_q.size();
				case (mode)
					6: begin
						// cut short somewhere inside
						tlen   = $urandom_range(1, size - 1);
						n_send = tlen + $urandom_range(0, 2);
					end
					7: begin
						// largest length: the walk stays open
						tlen   = 16'hFFFF;
						n_send = size;
					end
					8: begin
						// longer than the image: random bytes make further headers
						tlen   = size + $urandom_range(0, 20);
						n_send = tlen + $urandom_range(0, 2);
					end
					9: begin
						// pure noise
						tbl_q.delete();
						tlen   = $urandom_range(4, 24);
						n_send = tlen;
					end
					default: begin
						tlen   = size;
						n_send = size;
					end
				endcase
				run_table(16'(tlen), n_send, ($urandom_range(0, 19) != 0), 1'b0);
				n_rand += n_send;
			end
			t++;
		end

		burst = 1'b0;
		settle();
		if (n_errors == 0)
			$display("smbios_structure_walker_tb OK");
		else
			$display("smbios_structure_walker_tb NOT OK");
		$finish;
	end

endmodule
